@@ hdl/sphc_pkg.sv @@
// ----------------------------------------------------------------------------
// sphc_pkg
// Shared types and constants of the stepper position and homing controller.
// ----------------------------------------------------------------------------
package sphc_pkg;

  localparam int POS_W   = 32;    // signed step position width
  localparam int COIL_W  = 8;     // width of the coil enable vector
  localparam int PHASE_W = 3;     // index of one coil
  localparam int CNT_W   = 4;     // coil_count register width
  localparam int FREQ_W  = 10;    // step_freq register width
  localparam int TICK_W  = 10;    // millisecond tick counter width
  localparam int ACT_W   = 2;     // action code width

  localparam int MAX_COILS = 8;
  localparam int MS_PER_S  = 1000;

  localparam logic [FREQ_W-1:0] FREQ_RESET  = FREQ_W'(100);
  localparam logic [CNT_W-1:0]  COILS_RESET = CNT_W'(4);

  // Action codes carried in s_tuser.
  localparam logic [ACT_W-1:0] ACT_TICK  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DEST  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_HOME  = 2'd2;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_FREQ  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COIL_COUNT = 1'd1;

  localparam int IN_DATA_W  = 40;  // target, detector, zero fill
  localparam int OUT_DATA_W = 80;  // coil_drive .. stepped, zero fill

  typedef struct packed {
    logic              stepped;
    logic              moving;
    logic              homing;
    logic [POS_W-1:0]  destination;
    logic [POS_W-1:0]  position;
    logic [COIL_W-1:0] coil_drive;
  } result_t;

endpackage

@@ hdl/stepper_position_homing_controller.sv @@
// ----------------------------------------------------------------------------
// stepper_position_homing_controller
// Stepper motor controller with timed stepping toward a destination and a
// homing run that steps down until the home detector reads high.
// ----------------------------------------------------------------------------
// An accepted item is held in the input register, and its result is then
// registered in the result register, which drives the output.
// Throughput: one item per cycle while the result side is free or draining;
// the result register and the input register then advance together.
// Reset: homing is active, position, destination, timer and phase are zero,
// all coils are off, step_freq reads 100 and coil_count reads 4.
// ----------------------------------------------------------------------------
module stepper_position_homing_controller (
  input  logic                             clk,
  input  logic                             rst,
  // Item input.
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // [31:0] target (signed), [32] detector, [39:33] zero
  input  logic [sphc_pkg::IN_DATA_W-1:0]   s_tdata,
  // [1:0] action
  input  logic [sphc_pkg::ACT_W-1:0]       s_tuser,
  // Result output.
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [7:0] coil_drive, [39:8] position, [71:40] destination, [72] homing,
  // [73] moving, [74] stepped, [79:75] zero
  output logic [sphc_pkg::OUT_DATA_W-1:0]  m_tdata,
  // Configuration write channel.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sphc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sphc_pkg::FREQ_W-1:0]      cfg_data
);
  import sphc_pkg::*;

  // Configuration registers. The step period floor(1000 / step_freq) is
  // never stored: the timer expires when (tick + 2) * step_freq > 1000,
  // which is the same test as tick + 1 >= floor(1000 / step_freq).
  logic [FREQ_W-1:0]  step_freq;
  logic [CNT_W-1:0]   coil_count;

  // Controller state.
  logic [POS_W-1:0]   position_count, position_next;
  logic [POS_W-1:0]   destination_count, destination_next;
  logic               homing_flag, homing_next;
  logic               moving_flag, moving_next;
  logic [TICK_W-1:0]  tick_count, tick_next;
  logic [PHASE_W-1:0] phase_index, phase_next;
  logic [COIL_W-1:0]  coil_pattern, coil_next;
  logic               stepped;

  // Input register.
  logic               s1_valid;
  logic [ACT_W-1:0]   s1_action;
  logic [POS_W-1:0]   s1_target;
  logic               s1_detector;

  logic               advance;
  result_t            result;

  // The input register moves into the result register when the result side
  // has room this cycle.
  assign advance  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_action   <= s_tuser;
      s1_target   <= s_tdata[POS_W-1:0];
      s1_detector <= s_tdata[POS_W];
    end
  end

  // Out-of-range writes are dropped; coil_count tests cfg_data[3:0] only.
  always_ff @(posedge clk) begin
    if (rst) begin
      step_freq  <= FREQ_RESET;
      coil_count <= COILS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_STEP_FREQ: begin
          if (cfg_data != '0 && cfg_data <= FREQ_W'(MS_PER_S)) begin
            step_freq <= cfg_data;
          end
        end
        REG_COIL_COUNT: begin
          if (cfg_data[CNT_W-1:0] != '0 &&
              cfg_data[CNT_W-1:0] <= CNT_W'(MAX_COILS)) begin
            coil_count <= cfg_data[CNT_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Timer arithmetic and step helpers.
  logic [TICK_W:0]          tick_inc;
  logic [TICK_W+FREQ_W:0]   tick_prod;
  logic                     expire;
  logic                     dir_up;
  logic [POS_W-1:0]         pos_stepped;
  logic [PHASE_W-1:0]       phase_stepped;
  logic [CNT_W-1:0]         phase_plus;

  assign tick_inc  = {1'b0, tick_count} + (TICK_W+1)'(1);
  assign tick_prod = (tick_inc + (TICK_W+1)'(1)) * step_freq;
  assign expire    = tick_prod > (TICK_W+FREQ_W+1)'(MS_PER_S);
  assign phase_plus = {1'b0, phase_index} + CNT_W'(1);

  // Homing always steps down; a move steps toward the destination, which is
  // compared as a signed value.
  assign dir_up = !homing_flag &&
                  ($signed(position_count) < $signed(destination_count));

  always_comb begin
    if (dir_up) begin
      pos_stepped = position_count + POS_W'(1);
      if (phase_plus >= coil_count) begin
        phase_stepped = '0;
      end else begin
        phase_stepped = phase_plus[PHASE_W-1:0];
      end
    end else begin
      pos_stepped = position_count - POS_W'(1);
      // A phase left above a reduced coil count wraps to the top coil.
      if (phase_index == '0 || {1'b0, phase_index} >= coil_count) begin
        phase_stepped = PHASE_W'(coil_count - CNT_W'(1));
      end else begin
        phase_stepped = phase_index - PHASE_W'(1);
      end
    end
  end

  // Next-state logic for the item sitting in the input register.
  always_comb begin
    position_next    = position_count;
    destination_next = destination_count;
    homing_next      = homing_flag;
    moving_next      = moving_flag;
    tick_next        = tick_count;
    phase_next       = phase_index;
    coil_next        = coil_pattern;
    stepped          = 1'b0;

    case (s1_action)
      ACT_TICK: begin
        if (homing_flag) begin
          if (s1_detector) begin
            // Home reached: zero the axis, leave the coils energized.
            position_next    = '0;
            destination_next = '0;
            phase_next       = '0;
            homing_next      = 1'b0;
            moving_next      = 1'b0;
            tick_next        = '0;
          end else if (expire) begin
            tick_next     = '0;
            position_next = pos_stepped;
            phase_next    = phase_stepped;
            coil_next     = COIL_W'(1) << phase_stepped;
            stepped       = 1'b1;
          end else begin
            tick_next = tick_inc[TICK_W-1:0];
          end
        end else if (moving_flag) begin
          if (expire) begin
            tick_next = '0;
            if (position_count != destination_count) begin
              position_next = pos_stepped;
              phase_next    = phase_stepped;
              coil_next     = COIL_W'(1) << phase_stepped;
              stepped       = 1'b1;
            end
            if (position_next == destination_count) begin
              moving_next = 1'b0;
            end
          end else begin
            tick_next = tick_inc[TICK_W-1:0];
          end
        end else begin
          tick_next = '0;
        end
      end
      ACT_DEST: begin
        // Ignored while homing or when the target is already the position.
        if (!homing_flag && s1_target != position_count) begin
          destination_next = s1_target;
          if (!moving_flag) begin
            tick_next = '0;
          end
          moving_next = 1'b1;
        end
      end
      ACT_HOME: begin
        homing_next = 1'b1;
        moving_next = 1'b0;
        tick_next   = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position_count    <= '0;
      destination_count <= '0;
      homing_flag       <= 1'b1;
      moving_flag       <= 1'b0;
      tick_count        <= '0;
      phase_index       <= '0;
      coil_pattern      <= '0;
    end else if (advance) begin
      position_count    <= position_next;
      destination_count <= destination_next;
      homing_flag       <= homing_next;
      moving_flag       <= moving_next;
      tick_count        <= tick_next;
      phase_index       <= phase_next;
      coil_pattern      <= coil_next;
    end
  end

  // Result register: shows the state after the item together with its step
  // flag.
  always_comb begin
    result.coil_drive  = coil_next;
    result.position    = position_next;
    result.destination = destination_next;
    result.homing      = homing_next;
    result.moving      = moving_next;
    result.stepped     = stepped;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {(OUT_DATA_W - $bits(result_t))'(0), result};
    end
  end

endmodule
